[hw/rtl/scft_pkg.sv]
// Types, codes and constants for the serial command frame transactor.
// No dependencies; used by serial_command_frame_transactor.
package scft_pkg;

    localparam int TICKS_PER_SECOND_DEF = 10;
    localparam int LIMIT_W              = 20;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};
    localparam int RES_MAX              = 5;
    localparam int RES_CNT_W            = 3;
    localparam logic [7:0] CHAR_ACK      = 8'h41;
    localparam logic [7:0] CHAR_COMPLETE = 8'h43;

    typedef enum logic [1:0] {
        IN_START   = 2'd0,
        IN_PAYLOAD = 2'd1,
        IN_RX      = 2'd2,
        IN_TICK    = 2'd3
    } t_in_kind;

    typedef enum logic [1:0] {
        OUT_TX   = 2'd0,
        OUT_RX   = 2'd1,
        OUT_DONE = 2'd2
    } t_out_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TIMEOUT     = 2'd1,
        ST_NO_ACK      = 2'd2,
        ST_NO_COMPLETE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ACK1  = 3'd1,
        PH_SEND  = 3'd2,
        PH_ACK2  = 3'd3,
        PH_RECV  = 3'd4,
        PH_RCHK  = 3'd5,
        PH_DONEW = 3'd6
    } t_phase;

    typedef struct packed {
        t_out_kind  kind;
        logic [7:0] data;
        logic       cmd;
        t_status    status;
        logic       last;
    } t_result;

endpackage

[hw/rtl/serial_command_frame_transactor.sv]
// Host-side command frame transactor: frame, ack, payload, response, complete.
// Depends on scft_pkg for codes, phase enum and the result word type.
//
//  channel | direction | handshake          | payload
//  in      | to block  | i_valid / o_stall  | i_kind, i_data_byte, frame fields, lengths
//  out     | from block| o_valid / i_stall  | o_out_kind, o_out_byte, o_cmd_line, o_status, o_last
//
// An input word is worked combinationally and its results are loaded into a
// five-entry output shift line, drained one word per cycle at its head while i_stall is low.
// A start word loads five results (the frame bytes), a closing payload byte
// two, and every other word at most one.
// Synchronous active-low reset returns to idle with an empty output line.
// o_stall is high while more than one result is pending, or one is pending
// and not taken this cycle.
module serial_command_frame_transactor #(
    parameter int TICKS_PER_SECOND = scft_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_device_id,
    input  logic [7:0]  i_command_code,
    input  logic [7:0]  i_aux_first,
    input  logic [7:0]  i_aux_second,
    input  logic [15:0] i_out_len,
    input  logic [15:0] i_in_len,
    input  logic [15:0] i_timeout_sec,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_cmd_line,
    output logic [1:0]  o_status,
    output logic        o_last
);

    localparam int LW     = scft_pkg::LIMIT_W;
    localparam int RAW_W  = 16 + $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W = (RAW_W > LW + 1) ? RAW_W : LW + 1;
    localparam int CW     = scft_pkg::RES_CNT_W;
    localparam int RN     = scft_pkg::RES_MAX;

    scft_pkg::t_phase  r_phase, n_phase;
    logic [15:0]       r_byte_count, n_byte_count;
    logic [15:0]       r_send_len, n_send_len;
    logic [15:0]       r_recv_len, n_recv_len;
    logic [7:0]        r_running_xor, n_running_xor;
    logic [LW-1:0]     r_tick_limit, n_tick_limit;
    logic [LW-1:0]     r_tick_count, n_tick_count;

    scft_pkg::t_result r_res [RN];
    scft_pkg::t_result n_res [RN];
    logic [CW-1:0]     r_cnt, n_cnt;

    logic              w_in_acc, w_out_take;
    logic [15:0]       w_cnt_inc;
    logic [7:0]        w_xor_inc, w_frame_xor;
    logic [LW-1:0]     w_tick_inc;
    logic [PROD_W-1:0] w_prod;
    logic              w_timed;
    logic              w_ack_ok;
    scft_pkg::t_in_kind w_kind;

    assign w_kind      = scft_pkg::t_in_kind'(i_kind);
    assign o_valid     = (r_cnt != '0);
    assign w_out_take  = o_valid && !i_stall;
    assign o_stall     = (r_cnt > CW'(1)) || ((r_cnt == CW'(1)) && i_stall);
    assign w_in_acc    = i_valid && !o_stall;

    assign o_out_kind  = r_res[0].kind;
    assign o_out_byte  = r_res[0].data;
    assign o_cmd_line  = r_res[0].cmd;
    assign o_status    = r_res[0].status;
    assign o_last      = r_res[0].last;

    assign w_cnt_inc   = r_byte_count + 16'd1;
    assign w_xor_inc   = r_running_xor ^ i_data_byte;
    assign w_frame_xor = i_device_id ^ i_command_code ^ i_aux_first ^ i_aux_second;
    assign w_tick_inc  = (r_tick_count < scft_pkg::LIMIT_MAX) ? r_tick_count + LW'(1)
                                                               : r_tick_count;
    assign w_prod      = PROD_W'(i_timeout_sec) * PROD_W'(TICKS_PER_SECOND);
    assign w_ack_ok    = (i_data_byte == scft_pkg::CHAR_ACK);
    assign w_timed     = (r_phase == scft_pkg::PH_ACK1) || (r_phase == scft_pkg::PH_ACK2) ||
                         (r_phase == scft_pkg::PH_DONEW) ||
                         ((r_phase == scft_pkg::PH_RECV) && (r_byte_count == 16'd0));

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_send_len    = r_send_len;
        n_recv_len    = r_recv_len;
        n_running_xor = r_running_xor;
        n_tick_limit  = r_tick_limit;
        n_tick_count  = r_tick_count;
        unique case (w_kind)
            scft_pkg::IN_START: begin
                if (r_phase == scft_pkg::PH_IDLE) begin
                    n_send_len    = i_out_len;
                    n_recv_len    = i_in_len;
                    n_tick_limit  = (w_prod > PROD_W'(scft_pkg::LIMIT_MAX)) ?
                                    scft_pkg::LIMIT_MAX : w_prod[LW-1:0];
                    n_running_xor = 8'h00;
                    n_phase       = scft_pkg::PH_ACK1;
                    n_tick_count  = '0;
                    n_byte_count  = '0;
                end
            end
            scft_pkg::IN_PAYLOAD: begin
                if (r_phase == scft_pkg::PH_SEND) begin
                    n_running_xor = w_xor_inc;
                    n_byte_count  = w_cnt_inc;
                    if (w_cnt_inc >= r_send_len) begin
                        n_phase      = scft_pkg::PH_ACK2;
                        n_tick_count = '0;
                        n_byte_count = '0;
                    end
                end
            end
            scft_pkg::IN_RX: begin
                unique case (r_phase)
                    scft_pkg::PH_ACK1: begin
                        if (!w_ack_ok) begin
                            n_phase = scft_pkg::PH_IDLE;
                        end else if (r_send_len != 16'd0) begin
                            n_phase       = scft_pkg::PH_SEND;
                            n_byte_count  = '0;
                            n_running_xor = 8'h00;
                        end else begin
                            n_phase      = (r_recv_len != 16'd0) ? scft_pkg::PH_RECV
                                                                  : scft_pkg::PH_DONEW;
                            n_tick_count = '0;
                            n_byte_count = '0;
                        end
                    end
                    scft_pkg::PH_ACK2: begin
                        if (!w_ack_ok) begin
                            n_phase = scft_pkg::PH_IDLE;
                        end else begin
                            n_phase      = (r_recv_len != 16'd0) ? scft_pkg::PH_RECV
                                                                  : scft_pkg::PH_DONEW;
                            n_tick_count = '0;
                            n_byte_count = '0;
                        end
                    end
                    scft_pkg::PH_RECV: begin
                        n_byte_count = w_cnt_inc;
                        if (w_cnt_inc >= r_recv_len) begin
                            n_phase = scft_pkg::PH_RCHK;
                        end
                    end
                    scft_pkg::PH_RCHK: begin
                        n_phase      = scft_pkg::PH_DONEW;
                        n_tick_count = '0;
                        n_byte_count = '0;
                    end
                    scft_pkg::PH_DONEW: n_phase = scft_pkg::PH_IDLE;
                    default: ;
                endcase
            end
            scft_pkg::IN_TICK: begin
                if (w_timed) begin
                    n_tick_count = w_tick_inc;
                    if (w_tick_inc >= r_tick_limit) begin
                        n_phase = scft_pkg::PH_IDLE;
                    end
                end
            end
        endcase
    end

    // results of the word
    always_comb begin
        for (int i = 0; i < RN; i++) begin
            n_res[i] = '{kind: scft_pkg::OUT_TX, data: 8'h00, cmd: 1'b0,
                         status: scft_pkg::ST_OK, last: 1'b0};
        end
        n_cnt = '0;
        unique case (w_kind)
            scft_pkg::IN_START: begin
                if (r_phase == scft_pkg::PH_IDLE) begin
                    n_res[0].data = i_device_id;
                    n_res[1].data = i_command_code;
                    n_res[2].data = i_aux_first;
                    n_res[3].data = i_aux_second;
                    n_res[4].data = w_frame_xor;
                    for (int i = 0; i < RN; i++) begin
                        n_res[i].cmd = 1'b1;
                    end
                    n_res[4].last = 1'b1;
                    n_cnt = CW'(RN);
                end
            end
            scft_pkg::IN_PAYLOAD: begin
                if (r_phase == scft_pkg::PH_SEND) begin
                    n_res[0].data = i_data_byte;
                    if (w_cnt_inc >= r_send_len) begin
                        n_res[1].data = w_xor_inc;
                        n_res[1].last = 1'b1;
                        n_cnt = CW'(2);
                    end else begin
                        n_res[0].last = 1'b1;
                        n_cnt = CW'(1);
                    end
                end
            end
            scft_pkg::IN_RX: begin
                n_res[0].last = 1'b1;
                n_res[0].kind = scft_pkg::OUT_DONE;
                unique case (r_phase)
                    scft_pkg::PH_ACK1, scft_pkg::PH_ACK2: begin
                        n_res[0].status = scft_pkg::ST_NO_ACK;
                        n_cnt = w_ack_ok ? CW'(0) : CW'(1);
                    end
                    scft_pkg::PH_RECV: begin
                        n_res[0].kind = scft_pkg::OUT_RX;
                        n_res[0].data = i_data_byte;
                        n_cnt = CW'(1);
                    end
                    scft_pkg::PH_DONEW: begin
                        n_res[0].status = (i_data_byte == scft_pkg::CHAR_COMPLETE) ?
                                          scft_pkg::ST_OK : scft_pkg::ST_NO_COMPLETE;
                        n_cnt = CW'(1);
                    end
                    default: ;
                endcase
            end
            scft_pkg::IN_TICK: begin
                n_res[0].kind   = scft_pkg::OUT_DONE;
                n_res[0].status = scft_pkg::ST_TIMEOUT;
                n_res[0].last   = 1'b1;
                if (w_timed && (w_tick_inc >= r_tick_limit)) begin
                    n_cnt = CW'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= scft_pkg::PH_IDLE;
            r_byte_count  <= '0;
            r_send_len    <= '0;
            r_recv_len    <= '0;
            r_running_xor <= '0;
            r_tick_limit  <= '0;
            r_tick_count  <= '0;
            r_cnt         <= '0;
        end else begin
            if (w_in_acc) begin
                r_phase       <= n_phase;
                r_byte_count  <= n_byte_count;
                r_send_len    <= n_send_len;
                r_recv_len    <= n_recv_len;
                r_running_xor <= n_running_xor;
                r_tick_limit  <= n_tick_limit;
                r_tick_count  <= n_tick_count;
                r_cnt         <= n_cnt;
            end else if (w_out_take) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int i = 0; i < RN; i++) begin
                r_res[i] <= n_res[i];
            end
        end else if (w_out_take) begin
            for (int i = 0; i < RN - 1; i++) begin
                r_res[i] <= r_res[i + 1];
            end
        end
    end

    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    a_last_is_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_cnt == CW'(1)))
        else $error("last flag not on final pending result");

    a_start_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_kind == scft_pkg::IN_START) && (r_phase == scft_pkg::PH_IDLE))
        |=> (o_valid && o_cmd_line && (r_cnt == CW'(RN)) && (r_phase == scft_pkg::PH_ACK1)))
        else $error("start did not load a command frame");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(RN))
        else $error("result count overflow");

endmodule

[test/tb_top.sv]
// Self-checking testbench for serial_command_frame_transactor: drives command
// exchanges, stray words and timeouts, and checks every link result in order.
// Depends on scft_pkg and the transactor RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TPS = scft_pkg::TICKS_PER_SECOND_DEF;

    typedef struct {
        scft_pkg::t_in_kind kind;
        logic [7:0]  data;
        logic [7:0]  dev;
        logic [7:0]  op;
        logic [7:0]  aux1;
        logic [7:0]  aux2;
        logic [15:0] olen;
        logic [15:0] ilen;
        logic [15:0] tsec;
    } t_link_word;

    typedef enum logic [2:0] {
        FLT_NONE      = 3'd0,
        FLT_ACK1_BAD  = 3'd1,
        FLT_ACK1_LATE = 3'd2,
        FLT_ACK2_BAD  = 3'd3,
        FLT_ACK2_LATE = 3'd4,
        FLT_RESP_LATE = 3'd5,
        FLT_DONE_BAD  = 3'd6,
        FLT_DONE_LATE = 3'd7
    } t_fault;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_stall        = 1'b0;
    logic [1:0]  i_kind         = '0;
    logic [7:0]  i_data_byte    = '0;
    logic [7:0]  i_device_id    = '0;
    logic [7:0]  i_command_code = '0;
    logic [7:0]  i_aux_first    = '0;
    logic [7:0]  i_aux_second   = '0;
    logic [15:0] i_out_len      = '0;
    logic [15:0] i_in_len       = '0;
    logic [15:0] i_timeout_sec  = '0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_out_byte;
    logic        o_cmd_line;
    logic [1:0]  o_status;
    logic        o_last;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          words_counted  = 0;
    int          exchanges      = 0;
    int          results_checked = 0;
    int          errors         = 0;
    int          outcomes [4]   = '{0, 0, 0, 0};

    // predicted host state
    scft_pkg::t_phase   host_phase  = scft_pkg::PH_IDLE;
    logic [15:0]        link_count  = '0;
    logic [15:0]        payload_len = '0;
    logic [15:0]        reply_len   = '0;
    logic [7:0]         payload_xor = '0;
    logic [scft_pkg::LIMIT_W-1:0] wait_limit = '0;
    logic [scft_pkg::LIMIT_W-1:0] wait_ticks = '0;
    scft_pkg::t_result  link_expected [$];

    serial_command_frame_transactor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_data_byte    (i_data_byte),
        .i_device_id    (i_device_id),
        .i_command_code (i_command_code),
        .i_aux_first    (i_aux_first),
        .i_aux_second   (i_aux_second),
        .i_out_len      (i_out_len),
        .i_in_len       (i_in_len),
        .i_timeout_sec  (i_timeout_sec),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_kind     (o_out_kind),
        .o_out_byte     (o_out_byte),
        .o_cmd_line     (o_cmd_line),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (errors < 50)
            $display("mismatch: %s", msg);
        errors++;
    endtask

    // ---------------- prediction ----------------

    task automatic queue_result(input scft_pkg::t_out_kind k, input logic [7:0] b,
                                input logic c, input scft_pkg::t_status s, input logic l);
        scft_pkg::t_result r;
        r.kind   = k;
        r.data   = b;
        r.cmd    = c;
        r.status = s;
        r.last   = l;
        link_expected.push_back(r);
    endtask

    task automatic close_exchange(input scft_pkg::t_status s);
        host_phase = scft_pkg::PH_IDLE;
        queue_result(scft_pkg::OUT_DONE, 8'h00, 1'b0, s, 1'b1);
    endtask

    task automatic begin_wait(input scft_pkg::t_phase p);
        host_phase = p;
        wait_ticks = '0;
        link_count = '0;
    endtask

    task automatic predict_link_output(input t_link_word w);
        logic [7:0]  frame [5];
        logic [35:0] limit;
        int          i;
        case (w.kind)
            scft_pkg::IN_START: begin
                if (host_phase == scft_pkg::PH_IDLE) begin
                    frame[0] = w.dev;
                    frame[1] = w.op;
                    frame[2] = w.aux1;
                    frame[3] = w.aux2;
                    frame[4] = w.dev ^ w.op ^ w.aux1 ^ w.aux2;
                    payload_len = w.olen;
                    reply_len   = w.ilen;
                    limit = 36'(w.tsec) * TPS;
                    wait_limit = (limit > 36'(scft_pkg::LIMIT_MAX)) ? scft_pkg::LIMIT_MAX
                                                                     : limit[scft_pkg::LIMIT_W-1:0];
                    payload_xor = '0;
                    begin_wait(scft_pkg::PH_ACK1);
                    for (i = 0; i < 5; i++)
                        queue_result(scft_pkg::OUT_TX, frame[i], 1'b1, scft_pkg::ST_OK, i == 4);
                end
            end
            scft_pkg::IN_PAYLOAD: begin
                if (host_phase == scft_pkg::PH_SEND) begin
                    payload_xor = payload_xor ^ w.data;
                    link_count  = link_count + 16'd1;
                    if (link_count >= payload_len) begin
                        queue_result(scft_pkg::OUT_TX, w.data, 1'b0, scft_pkg::ST_OK, 1'b0);
                        queue_result(scft_pkg::OUT_TX, payload_xor, 1'b0, scft_pkg::ST_OK, 1'b1);
                        begin_wait(scft_pkg::PH_ACK2);
                    end else begin
                        queue_result(scft_pkg::OUT_TX, w.data, 1'b0, scft_pkg::ST_OK, 1'b1);
                    end
                end
            end
            scft_pkg::IN_RX: begin
                case (host_phase)
                    scft_pkg::PH_ACK1: begin
                        if (w.data != scft_pkg::CHAR_ACK) begin
                            close_exchange(scft_pkg::ST_NO_ACK);
                        end else if (payload_len != 0) begin
                            host_phase  = scft_pkg::PH_SEND;
                            link_count  = '0;
                            payload_xor = '0;
                        end else begin
                            begin_wait(reply_len != 0 ? scft_pkg::PH_RECV : scft_pkg::PH_DONEW);
                        end
                    end
                    scft_pkg::PH_ACK2: begin
                        if (w.data != scft_pkg::CHAR_ACK)
                            close_exchange(scft_pkg::ST_NO_ACK);
                        else
                            begin_wait(reply_len != 0 ? scft_pkg::PH_RECV : scft_pkg::PH_DONEW);
                    end
                    scft_pkg::PH_RECV: begin
                        link_count = link_count + 16'd1;
                        if (link_count >= reply_len)
                            host_phase = scft_pkg::PH_RCHK;
                        queue_result(scft_pkg::OUT_RX, w.data, 1'b0, scft_pkg::ST_OK, 1'b1);
                    end
                    scft_pkg::PH_RCHK: begin_wait(scft_pkg::PH_DONEW);
                    scft_pkg::PH_DONEW:
                        close_exchange(w.data == scft_pkg::CHAR_COMPLETE ? scft_pkg::ST_OK
                                                                          : scft_pkg::ST_NO_COMPLETE);
                    default: ;
                endcase
            end
            scft_pkg::IN_TICK: begin
                if (host_phase == scft_pkg::PH_ACK1 || host_phase == scft_pkg::PH_ACK2
                    || host_phase == scft_pkg::PH_DONEW
                    || (host_phase == scft_pkg::PH_RECV && link_count == 0)) begin
                    if (wait_ticks < scft_pkg::LIMIT_MAX)
                        wait_ticks = wait_ticks + 1'b1;
                    if (wait_ticks >= wait_limit)
                        close_exchange(scft_pkg::ST_TIMEOUT);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch_inputs
        t_link_word w;
        if (i_rst_n && i_valid && !o_stall) begin
            w.kind = scft_pkg::t_in_kind'(i_kind);
            w.data = i_data_byte;
            w.dev  = i_device_id;
            w.op   = i_command_code;
            w.aux1 = i_aux_first;
            w.aux2 = i_aux_second;
            w.olen = i_out_len;
            w.ilen = i_in_len;
            w.tsec = i_timeout_sec;
            predict_link_output(w);
        end
    end

    always @(posedge i_clk) begin : check_results
        scft_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (link_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                          o_out_kind, o_out_byte));
            end else begin
                want = link_expected.pop_front();
                if (o_out_kind !== want.kind)
                    report_mismatch($sformatf("result %0d kind %0h want %0h",
                                              results_checked, o_out_kind, want.kind));
                if (o_out_byte !== want.data)
                    report_mismatch($sformatf("result %0d byte %02h want %02h",
                                              results_checked, o_out_byte, want.data));
                if (o_cmd_line !== want.cmd)
                    report_mismatch($sformatf("result %0d cmd_line %0h want %0h",
                                              results_checked, o_cmd_line, want.cmd));
                if (o_status !== want.status)
                    report_mismatch($sformatf("result %0d status %0h want %0h",
                                              results_checked, o_status, want.status));
                if (o_last !== want.last)
                    report_mismatch($sformatf("result %0d last %0h want %0h",
                                              results_checked, o_last, want.last));
                if (want.kind == scft_pkg::OUT_DONE)
                    outcomes[want.status]++;
            end
            results_checked++;
        end
    end

    // ---------------- stimulus ----------------

    function automatic t_link_word random_word();
        t_link_word w;
        w.kind = scft_pkg::t_in_kind'($urandom_range(3));
        w.data = 8'($urandom);
        w.dev  = 8'($urandom);
        w.op   = 8'($urandom);
        w.aux1 = 8'($urandom);
        w.aux2 = 8'($urandom);
        w.olen = 16'($urandom);
        w.ilen = 16'($urandom);
        w.tsec = 16'($urandom);
        return w;
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] c);
        logic [7:0] b;
        b = 8'($urandom);
        if (b == c)
            b = ~c;
        return b;
    endfunction

    // Leaves i_valid high after acceptance; the next word replaces it or settle() drops it.
    task automatic send_word(input t_link_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind         = w.kind;
        i_data_byte    = w.data;
        i_device_id    = w.dev;
        i_command_code = w.op;
        i_aux_first    = w.aux1;
        i_aux_second   = w.aux2;
        i_out_len      = w.olen;
        i_in_len       = w.ilen;
        i_timeout_sec  = w.tsec;
        i_valid        = 1'b1;
        do @(posedge i_clk); while (o_stall);
        words_counted++;
    endtask

    task automatic send_simple(input scft_pkg::t_in_kind k, input logic [7:0] b);
        t_link_word w;
        w = random_word();
        w.kind = k;
        w.data = b;
        send_word(w);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_simple(scft_pkg::IN_TICK, 8'($urandom));
    endtask

    // a word the transactor must ignore in the current phase
    task automatic stray_word(input bit in_send);
        t_link_word w;
        w = random_word();
        if (in_send) begin
            case ($urandom_range(2))
                0: w.kind = scft_pkg::IN_START;
                1: w.kind = scft_pkg::IN_RX;
                default: w.kind = scft_pkg::IN_TICK;
            endcase
        end else begin
            w.kind = $urandom_range(1) ? scft_pkg::IN_START : scft_pkg::IN_PAYLOAD;
        end
        send_word(w);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (link_expected.size() != 0)
            @(posedge i_clk);
        repeat (2 * scft_pkg::RES_MAX) @(posedge i_clk);
    endtask

    task automatic exchange(input logic [7:0] dev, op, a1, a2,
                            input logic [15:0] olen, ilen, tsec,
                            input t_fault flt, input bit noisy);
        t_link_word  w;
        int unsigned calm;
        int unsigned late;
        int unsigned i;
        w = random_word();
        w.kind = scft_pkg::IN_START;
        w.dev  = dev;
        w.op   = op;
        w.aux1 = a1;
        w.aux2 = a2;
        w.olen = olen;
        w.ilen = ilen;
        w.tsec = tsec;
        send_word(w);
        exchanges++;
        calm = (noisy && tsec != 0) ? 3 : 0;
        late = (tsec == 0) ? 1 : tsec * TPS;

        if (noisy)
            stray_word(1'b0);
        send_ticks($urandom_range(calm));
        if (flt == FLT_ACK1_BAD) begin
            send_simple(scft_pkg::IN_RX, other_than(scft_pkg::CHAR_ACK));
            return;
        end
        if (flt == FLT_ACK1_LATE) begin
            send_ticks(late);
            return;
        end
        send_simple(scft_pkg::IN_RX, scft_pkg::CHAR_ACK);

        if (olen != 0) begin
            for (i = 0; i < olen; i++) begin
                if (noisy && $urandom_range(3) == 0)
                    stray_word(1'b1);
                send_simple(scft_pkg::IN_PAYLOAD, 8'($urandom));
            end
            send_ticks($urandom_range(calm));
            if (noisy)
                stray_word(1'b0);
            if (flt == FLT_ACK2_BAD) begin
                send_simple(scft_pkg::IN_RX, other_than(scft_pkg::CHAR_ACK));
                return;
            end
            if (flt == FLT_ACK2_LATE) begin
                send_ticks(late);
                return;
            end
            send_simple(scft_pkg::IN_RX, scft_pkg::CHAR_ACK);
        end

        if (ilen != 0) begin
            send_ticks($urandom_range(calm));
            if (flt == FLT_RESP_LATE) begin
                send_ticks(late);
                return;
            end
            for (i = 0; i < ilen; i++) begin
                send_simple(scft_pkg::IN_RX, 8'($urandom));
                // only the first response byte is timed
                if (noisy && $urandom_range(3) == 0) begin
                    send_ticks($urandom_range(3, 1));
                    stray_word(1'b0);
                end
            end
            send_simple(scft_pkg::IN_RX, 8'($urandom));
        end

        send_ticks($urandom_range(calm));
        if (noisy)
            stray_word(1'b0);
        if (flt == FLT_DONE_LATE) begin
            send_ticks(late);
            return;
        end
        send_simple(scft_pkg::IN_RX, flt == FLT_DONE_BAD ? other_than(scft_pkg::CHAR_COMPLETE)
                                                          : scft_pkg::CHAR_COMPLETE);
    endtask

    function automatic logic [15:0] random_len();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'd0;
            9: return 16'($urandom_range(20, 7));
            default: return 16'($urandom_range(6, 1));
        endcase
    endfunction

    // ---------------- tests ----------------

    task automatic test_frame_extremes();
        exchange(8'hFF, 8'h00, 8'hFF, 8'h00, 16'd0, 16'd0, 16'hFFFF, FLT_NONE, 1'b0);
        exchange(8'h00, 8'hFF, 8'h00, 8'hFF, 16'd0, 16'd0, 16'd0, FLT_ACK1_LATE, 1'b0);
    endtask

    task automatic test_missing_ack();
        exchange(8'h5A, 8'hA5, 8'h3C, 8'hC3, 16'd0, 16'd0, 16'd1, FLT_ACK1_BAD, 1'b0);
    endtask

    task automatic test_payload_and_reply();
        exchange(8'h12, 8'h34, 8'h56, 8'h78, 16'd2, 16'd2, 16'd1, FLT_DONE_BAD, 1'b0);
        exchange(8'h9A, 8'hBC, 8'hDE, 8'hF0, 16'd1, 16'd0, 16'd0, FLT_ACK2_LATE, 1'b0);
    endtask

    task automatic test_idle_strays();
        send_simple(scft_pkg::IN_RX, scft_pkg::CHAR_ACK);
        send_simple(scft_pkg::IN_TICK, 8'h00);
        send_simple(scft_pkg::IN_PAYLOAD, 8'hFF);
    endtask

    task automatic test_random_exchanges(input int target);
        int          first;
        t_fault      flt;
        logic [15:0] tsec;
        int unsigned r;
        t_link_word  w;
        first = words_counted;
        while (words_counted - first < target) begin
            r = $urandom_range(9);
            if (r < 3)
                tsec = 16'd0;
            else if (r < 7)
                tsec = 16'($urandom_range(2, 1));
            else if (r < 9)
                tsec = 16'($urandom);
            else
                tsec = 16'hFFFF;
            r = $urandom_range(14);
            flt = (r <= 7) ? FLT_NONE : t_fault'(r - 7);
            if (tsec > 2 && (flt == FLT_ACK1_LATE || flt == FLT_ACK2_LATE
                             || flt == FLT_RESP_LATE || flt == FLT_DONE_LATE))
                flt = FLT_NONE;
            exchange(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     random_len(), random_len(), tsec, flt, 1'b1);
            if ($urandom_range(3) == 0) begin
                w = random_word();
                w.kind = scft_pkg::t_in_kind'($urandom_range(3, 1));
                send_word(w);
            end
        end
    endtask

    task automatic test_longest_transfer();
        exchange(8'hC3, 8'h3C, 8'h81, 8'h7E, 16'd24, 16'd24, 16'hFFFF, FLT_NONE, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct  = 20;
        recv_stall_pct = 71;
        test_frame_extremes();
        settle();
        test_missing_ack();
        test_payload_and_reply();
        settle();
        test_idle_strays();
        settle();
        test_random_exchanges(95);
        settle();

        send_idle_pct  = 71;
        recv_stall_pct = 20;
        test_random_exchanges(95);
        settle();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_exchanges(95);
        settle();
        test_longest_transfer();
        settle();

        $display("Ran %0d exchanges with %0d words driven; %0d results compared, %0d errors",
                 exchanges, words_counted, results_checked, errors);
        $display("Outcomes: ok %0d, timeout %0d, no ack %0d, no complete %0d",
                 outcomes[scft_pkg::ST_OK], outcomes[scft_pkg::ST_TIMEOUT],
                 outcomes[scft_pkg::ST_NO_ACK], outcomes[scft_pkg::ST_NO_COMPLETE]);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
